// ===== design/bis_pkg.sv =====
// Shared types, constants and helpers of the bilinear image sampler.
// No dependencies; bis_coord, bis_blend and the top refer to it by scoped names.
package bis_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int FRAC_BITS   = 8;

   localparam int COORD_BITS  = 20;
   localparam int PIX_W       = 8;
   localparam int INDEX_W     = 16;
   localparam int CFG_W       = 9;
   localparam int OUT_W       = 16;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = (MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH)
                                                         : $clog2(MAX_HEIGHT);
   localparam int WHOLE_W     = COORD_BITS - FRAC_BITS;
   localparam int WGT_W       = FRAC_BITS + 1;
   localparam int FRAC_ONE    = 1 << FRAC_BITS;
   localparam int OUT_SHIFT   = 2 * FRAC_BITS - 8;
   localparam int ROUND_HALF  = (OUT_SHIFT > 0) ? (1 << (OUT_SHIFT - 1)) : 0;
   localparam int OUT_MAX     = 65280;

   // Operation codes of an input beat
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Configuration register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Front-end stage: split and clamped coordinates, or a pending pixel write
   typedef struct packed {
      logic                 valid;
      logic                 is_write;
      logic [INDEX_W-1:0]   wr_index;
      logic [PIX_W-1:0]     wr_value;
      logic [IDX_W-1:0]     x0;
      logic [IDX_W-1:0]     x1;
      logic [IDX_W-1:0]     y0;
      logic [IDX_W-1:0]     y1;
      logic [FRAC_BITS-1:0] ax;
      logic [FRAC_BITS-1:0] ay;
   } coord_type;

   // Control travelling beside the memory read
   typedef struct packed {
      logic                 valid;
      logic [FRAC_BITS-1:0] ax;
      logic [FRAC_BITS-1:0] ay;
   } tap_ctrl_type;

   // Clamp a signed neighbour coordinate to [0, lim-1]
   function automatic logic [IDX_W-1:0] clamp_coord(
      input logic signed [WHOLE_W:0] v,
      input logic [CFG_W-1:0]        lim
   );
      logic signed [WHOLE_W:0] top;
      top = $signed((WHOLE_W+1)'(lim)) - $signed((WHOLE_W+1)'(1));
      if (v < 0) begin
         return '0;
      end else if (v > top) begin
         return IDX_W'(top);
      end else begin
         return IDX_W'(v);
      end
   endfunction

   // Effective image size: zero acts as one, above the maximum acts as the maximum
   function automatic logic [CFG_W-1:0] eff_size(
      input logic [CFG_W-1:0] v,
      input int               maxv
   );
      if (v == '0) begin
         return CFG_W'(1);
      end else if ({1'b0, v} > (CFG_W+1)'(maxv)) begin
         return CFG_W'(maxv);
      end else begin
         return v;
      end
   endfunction

endpackage

// ===== design/bis_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read.
// Depends on nothing.
module bis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== design/bis_coord.sv =====
// Front-end stage: floors the coordinates, takes the weights and clamps neighbours.
// Depends on bis_pkg.
module bis_coord (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 operation,
   input  logic [bis_pkg::INDEX_W-1:0]          pixel_index,
   input  logic [bis_pkg::PIX_W-1:0]            pixel_value,
   input  logic signed [bis_pkg::COORD_BITS-1:0] sample_x,
   input  logic signed [bis_pkg::COORD_BITS-1:0] sample_y,
   input  logic [bis_pkg::CFG_W-1:0]            width_eff,
   input  logic [bis_pkg::CFG_W-1:0]            height_eff,
   output bis_pkg::coord_type                   coord
);

   logic signed [bis_pkg::WHOLE_W:0] x_whole;
   logic signed [bis_pkg::WHOLE_W:0] y_whole;
   logic signed [bis_pkg::WHOLE_W:0] x_next;
   logic signed [bis_pkg::WHOLE_W:0] y_next;
   logic                             valid_ff;
   bis_pkg::coord_type               coord_ff;
   bis_pkg::coord_type               coord_in;

   always_comb begin
      // floor is an arithmetic shift
      x_whole = (bis_pkg::WHOLE_W+1)'(sample_x >>> bis_pkg::FRAC_BITS);
      y_whole = (bis_pkg::WHOLE_W+1)'(sample_y >>> bis_pkg::FRAC_BITS);
      x_next  = x_whole + $signed((bis_pkg::WHOLE_W+1)'(1));
      y_next  = y_whole + $signed((bis_pkg::WHOLE_W+1)'(1));

      coord_in          = coord_ff;
      coord_in.valid    = accept;
      coord_in.is_write = (operation == bis_pkg::OP_WRITE);
      coord_in.wr_index = pixel_index;
      coord_in.wr_value = pixel_value;
      coord_in.x0       = bis_pkg::clamp_coord(x_whole, width_eff);
      coord_in.x1       = bis_pkg::clamp_coord(x_next, width_eff);
      coord_in.y0       = bis_pkg::clamp_coord(y_whole, height_eff);
      coord_in.y1       = bis_pkg::clamp_coord(y_next, height_eff);
      coord_in.ax       = sample_x[bis_pkg::FRAC_BITS-1:0];
      coord_in.ay       = sample_y[bis_pkg::FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= coord_in.valid;
      end
      coord_ff <= coord_in;
   end

   always_comb begin
      coord       = coord_ff;
      coord.valid = valid_ff;
   end

endmodule

// ===== design/bis_blend.sv =====
// Blend stages: horizontal lerp of both rows, vertical lerp, rounding and output register.
// Depends on bis_pkg.
module bis_blend (
   input  logic                            clock,
   input  logic                            reset,
   input  bis_pkg::tap_ctrl_type           ctrl,
   input  logic [bis_pkg::PIX_W-1:0]       p00,
   input  logic [bis_pkg::PIX_W-1:0]       p10,
   input  logic [bis_pkg::PIX_W-1:0]       p01,
   input  logic [bis_pkg::PIX_W-1:0]       p11,
   output logic                            rsp_valid,
   output logic [bis_pkg::OUT_W-1:0]       rsp_sample_value
);

   localparam int ROW_W = bis_pkg::PIX_W + bis_pkg::WGT_W + 1;
   localparam int SUM_W = ROW_W + bis_pkg::WGT_W + 1;

   logic [bis_pkg::WGT_W-1:0]     ax;
   logic [bis_pkg::WGT_W-1:0]     bx;
   logic [bis_pkg::WGT_W-1:0]     ay_ext;
   logic [bis_pkg::WGT_W-1:0]     by;
   logic [ROW_W-1:0]              top_in;
   logic [ROW_W-1:0]              bottom_in;
   logic [ROW_W-1:0]              top_ff;
   logic [ROW_W-1:0]              bottom_ff;
   logic [bis_pkg::FRAC_BITS-1:0] ay_ff;
   logic                          row_valid_ff;
   logic [SUM_W-1:0]              sum;
   logic [SUM_W:0]                rounded;
   logic [bis_pkg::OUT_W-1:0]     value_in;
   logic                          rsp_valid_ff;
   logic [bis_pkg::OUT_W-1:0]     value_ff;

   always_comb begin
      ax        = bis_pkg::WGT_W'(ctrl.ax);
      bx        = bis_pkg::WGT_W'(bis_pkg::FRAC_ONE) - ax;
      top_in    = ROW_W'(bx) * ROW_W'(p00) + ROW_W'(ax) * ROW_W'(p10);
      bottom_in = ROW_W'(bx) * ROW_W'(p01) + ROW_W'(ax) * ROW_W'(p11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= ctrl.valid;
      end
      top_ff    <= top_in;
      bottom_ff <= bottom_in;
      ay_ff     <= ctrl.ay;
   end

   always_comb begin
      ay_ext  = bis_pkg::WGT_W'(ay_ff);
      by      = bis_pkg::WGT_W'(bis_pkg::FRAC_ONE) - ay_ext;
      sum     = SUM_W'(by) * SUM_W'(top_ff) + SUM_W'(ay_ext) * SUM_W'(bottom_ff);
      // round half up, then saturate at full white
      rounded = ((SUM_W+1)'(sum) + (SUM_W+1)'(bis_pkg::ROUND_HALF)) >> bis_pkg::OUT_SHIFT;
      if (rounded > (SUM_W+1)'(bis_pkg::OUT_MAX)) begin
         value_in = bis_pkg::OUT_W'(bis_pkg::OUT_MAX);
      end else begin
         value_in = bis_pkg::OUT_W'(rounded);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= row_valid_ff;
      end
      value_ff <= value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = value_ff;

endmodule

// ===== design/bilinear_image_sampler_unit.sv =====
// Bilinear image sampler, top level: configuration, pixel store and pipeline.
// Depends on bis_pkg, bis_ram, bis_coord and bis_blend.
//
// Usage
//  - Input channel: a beat is taken at a rising edge with start high and busy low.
//    req_operation selects a pixel write (req_pixel_index, req_pixel_value) or a
//    sample (req_sample_x, req_sample_y, signed with 8 fraction bits).
//  - Result channel: a sample returns one beat, rsp_sample_value with rsp_valid
//    high for one cycle, once through every pipeline stage. Writes return none.
//  - Throughput: one beat per cycle, writes and samples mixed freely; busy is low
//    except in reset and the cycle after it. The two store copies each give a row pair
//    of neighbours per cycle, so every sample issues all four reads at once.
//  - Beats stay in order, and a write is visible to every sample taken after it.
//  - The receiver cannot stall; results simply stream out.
//  - Configuration: csr_write_enable with csr_index and csr_write_data writes the
//    image width (index 0) or height (index 1) at once; write only while idle.
//  - Reset: synchronous, clears the pipeline and sets width and height to 256.
//    The store is not cleared: pixels read back only after they are written.
module bilinear_image_sampler_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic [bis_pkg::INDEX_W-1:0]           req_pixel_index,
   input  logic [bis_pkg::PIX_W-1:0]             req_pixel_value,
   input  logic signed [bis_pkg::COORD_BITS-1:0] req_sample_x,
   input  logic signed [bis_pkg::COORD_BITS-1:0] req_sample_y,
   output logic                                  rsp_valid,
   output logic [bis_pkg::OUT_W-1:0]             rsp_sample_value,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_index,
   input  logic [bis_pkg::CFG_W-1:0]             csr_write_data
);

   localparam int PROD_W = bis_pkg::IDX_W + bis_pkg::CFG_W;

   logic                          busy_ff;
   logic [bis_pkg::CFG_W-1:0]     image_width_ff;
   logic [bis_pkg::CFG_W-1:0]     image_height_ff;
   logic [bis_pkg::CFG_W-1:0]     width_eff;
   logic [bis_pkg::CFG_W-1:0]     height_eff;
   logic                          accept;
   bis_pkg::coord_type            coord;
   logic [PROD_W-1:0]             row0_base;
   logic [PROD_W-1:0]             row1_base;
   logic [bis_pkg::ADDR_W-1:0]    addr00;
   logic [bis_pkg::ADDR_W-1:0]    addr10;
   logic [bis_pkg::ADDR_W-1:0]    addr01;
   logic [bis_pkg::ADDR_W-1:0]    addr11;
   logic                          wr_en;
   logic [bis_pkg::ADDR_W-1:0]    wr_addr;
   logic [bis_pkg::PIX_W-1:0]     p00;
   logic [bis_pkg::PIX_W-1:0]     p10;
   logic [bis_pkg::PIX_W-1:0]     p01;
   logic [bis_pkg::PIX_W-1:0]     p11;
   bis_pkg::tap_ctrl_type         tap_ff;
   bis_pkg::tap_ctrl_type         tap_in;
   logic                          tap_valid_ff;
   bis_pkg::tap_ctrl_type         tap;

   // hold busy for the cycle after reset so no beat lands in a clearing pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= bis_pkg::CFG_W'(256);
         image_height_ff <= bis_pkg::CFG_W'(256);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bis_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            bis_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign width_eff  = bis_pkg::eff_size(image_width_ff, bis_pkg::MAX_WIDTH);
   assign height_eff = bis_pkg::eff_size(image_height_ff, bis_pkg::MAX_HEIGHT);

   // stage 1: floor, weights and clamping
   bis_coord u_coord (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .pixel_index (req_pixel_index),
      .pixel_value (req_pixel_value),
      .sample_x    (req_sample_x),
      .sample_y    (req_sample_y),
      .width_eff   (width_eff),
      .height_eff  (height_eff),
      .coord       (coord)
   );

   // stage 2: linear addresses of the four neighbours, store access
   always_comb begin
      row0_base = PROD_W'(coord.y0) * PROD_W'(width_eff);
      row1_base = PROD_W'(coord.y1) * PROD_W'(width_eff);
      addr00    = bis_pkg::ADDR_W'(row0_base + PROD_W'(coord.x0));
      addr10    = bis_pkg::ADDR_W'(row0_base + PROD_W'(coord.x1));
      addr01    = bis_pkg::ADDR_W'(row1_base + PROD_W'(coord.x0));
      addr11    = bis_pkg::ADDR_W'(row1_base + PROD_W'(coord.x1));
      // drop writes beyond the store
      wr_en     = coord.valid & coord.is_write &
                  ((bis_pkg::INDEX_W+1)'(coord.wr_index) <
                   (bis_pkg::INDEX_W+1)'(bis_pkg::STORE_DEPTH));
      wr_addr   = bis_pkg::ADDR_W'(coord.wr_index);
   end

   // both copies take every write; the first serves the upper row, the second the lower
   bis_ram #(
      .WIDTH (bis_pkg::PIX_W),
      .DEPTH (bis_pkg::STORE_DEPTH)
   ) u_store_row0 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (coord.wr_value),
      .rd_addr_a (addr00),
      .rd_addr_b (addr10),
      .rd_data_a (p00),
      .rd_data_b (p10)
   );

   bis_ram #(
      .WIDTH (bis_pkg::PIX_W),
      .DEPTH (bis_pkg::STORE_DEPTH)
   ) u_store_row1 (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (coord.wr_value),
      .rd_addr_a (addr01),
      .rd_addr_b (addr11),
      .rd_data_a (p01),
      .rd_data_b (p11)
   );

   // carry the weights alongside the registered read
   always_comb begin
      tap_in.valid = coord.valid & ~coord.is_write;
      tap_in.ax    = coord.ax;
      tap_in.ay    = coord.ay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff <= 1'b0;
      end else begin
         tap_valid_ff <= tap_in.valid;
      end
      tap_ff <= tap_in;
   end

   always_comb begin
      tap       = tap_ff;
      tap.valid = tap_valid_ff;
   end

   // stages 3 and 4: blend, round and present the result beat
   bis_blend u_blend (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (tap),
      .p00              (p00),
      .p10              (p10),
      .p01              (p01),
      .p11              (p11),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value)
   );

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for bilinear_image_sampler_unit: directed rows, then random beats.
// Depends on bis_pkg for the widths, operation codes and register indexes.
module testbench;
   import bis_pkg::*;

   // Cycles without an accepted beat or a result before the run is called hung
   localparam int STALL_LIMIT   = 2000;
   // Settling time after the last result: pipeline depth plus margin
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BEATS   = 192;
   localparam int PHASE_COUNT   = 9;
   localparam int DIRECTED_ROWS = 22;
   localparam logic LEVEL_TYPED   = 1'b1;
   localparam logic LEVEL_PREDICT = 1'b0;

   typedef struct packed {
      logic                         op;
      logic [INDEX_W-1:0]           index;
      logic [PIX_W-1:0]             value;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         typed;
      logic [OUT_W-1:0]             level;
   } stim_row_type;

   // Four neighbour addresses of one sample and the fractional weights
   typedef struct packed {
      logic [INDEX_W-1:0]   a00;
      logic [INDEX_W-1:0]   a10;
      logic [INDEX_W-1:0]   a01;
      logic [INDEX_W-1:0]   a11;
      logic [FRAC_BITS-1:0] ax;
      logic [FRAC_BITS-1:0] ay;
   } tap_set_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_operation = OP_WRITE;
   logic [INDEX_W-1:0]           req_pixel_index = '0;
   logic [PIX_W-1:0]             req_pixel_value = '0;
   logic signed [COORD_BITS-1:0] req_sample_x = '0;
   logic signed [COORD_BITS-1:0] req_sample_y = '0;
   logic                         rsp_valid;
   logic [OUT_W-1:0]             rsp_sample_value;
   logic                         csr_write_enable = 1'b0;
   logic                         csr_index = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0]             csr_write_data = '0;

   bilinear_image_sampler_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_pixel_index  (req_pixel_index),
      .req_pixel_value  (req_pixel_value),
      .req_sample_x     (req_sample_x),
      .req_sample_y     (req_sample_y),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the image, the geometry registers and the pending levels
   logic [PIX_W-1:0] pixel_mem   [STORE_DEPTH];
   bit               pixel_known [STORE_DEPTH];
   logic [CFG_W-1:0] cfg_width  = CFG_W'(256);
   logic [CFG_W-1:0] cfg_height = CFG_W'(256);
   logic [OUT_W-1:0] expected_levels [$];

   int error_count   = 0;
   int quiet_cycles  = 0;
   int idle_pct      = 0;
   int samples_sent  = 0;
   int writes_sent   = 0;
   int results_seen  = 0;
   int geometries    = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
   endtask

   // A size register of zero acts as one, anything past the maximum as the maximum
   function automatic int effective_extent(input logic [CFG_W-1:0] v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic int clamp_axis(input int v, input int extent);
      if (v < 0) return 0;
      if (v > extent - 1) return extent - 1;
      return v;
   endfunction

   function automatic tap_set_type locate_taps(input logic signed [COORD_BITS-1:0] sx,
                                               input logic signed [COORD_BITS-1:0] sy);
      tap_set_type t;
      int w, h, x0, y0, x1, y1, cx0, cx1, cy0, cy1;
      w  = effective_extent(cfg_width, MAX_WIDTH);
      h  = effective_extent(cfg_height, MAX_HEIGHT);
      // floor by arithmetic shift, the low bits are the weight fraction
      x0 = int'(sx) >>> FRAC_BITS;
      y0 = int'(sy) >>> FRAC_BITS;
      x1 = x0 + 1;
      y1 = y0 + 1;
      cx0 = clamp_axis(x0, w);
      cx1 = clamp_axis(x1, w);
      cy0 = clamp_axis(y0, h);
      cy1 = clamp_axis(y1, h);
      t.a00 = INDEX_W'(cx0 + cy0 * w);
      t.a10 = INDEX_W'(cx1 + cy0 * w);
      t.a01 = INDEX_W'(cx0 + cy1 * w);
      t.a11 = INDEX_W'(cx1 + cy1 * w);
      t.ax  = sx[FRAC_BITS-1:0];
      t.ay  = sy[FRAC_BITS-1:0];
      return t;
   endfunction

   function automatic logic [OUT_W-1:0] blend_level(input tap_set_type t);
      int ax, ay, bx, by, upper, lower, acc;
      ax = int'(t.ax);
      ay = int'(t.ay);
      bx = FRAC_ONE - ax;
      by = FRAC_ONE - ay;
      upper = bx * int'(pixel_mem[t.a00]) + ax * int'(pixel_mem[t.a10]);
      lower = bx * int'(pixel_mem[t.a01]) + ax * int'(pixel_mem[t.a11]);
      acc   = by * upper + ay * lower;
      // round to nearest, halves up
      acc   = (acc + ROUND_HALF) >>> OUT_SHIFT;
      if (acc > OUT_MAX) acc = OUT_MAX;
      return OUT_W'(acc);
   endfunction

   // Present one beat, hold it until taken, then book it against the shadow image.
   // Entered and left at a rising edge; start stays high for a back-to-back beat.
   task automatic send_beat(input logic op, input logic [INDEX_W-1:0] index,
                            input logic [PIX_W-1:0] value,
                            input logic signed [COORD_BITS-1:0] sx,
                            input logic signed [COORD_BITS-1:0] sy,
                            input logic typed, input logic [OUT_W-1:0] level);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_pixel_index <= index;
      req_pixel_value <= value;
      req_sample_x    <= sx;
      req_sample_y    <= sy;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_WRITE) begin
         pixel_mem[index]   = value;
         pixel_known[index] = 1'b1;
         writes_sent++;
      end else begin
         expected_levels.push_back(typed ? level : blend_level(locate_taps(sx, sy)));
         samples_sent++;
      end
   endtask

   // Never read an unwritten pixel: fill any missing neighbour first, then sample
   task automatic send_sample(input logic signed [COORD_BITS-1:0] sx,
                              input logic signed [COORD_BITS-1:0] sy,
                              input logic typed, input logic [OUT_W-1:0] level);
      tap_set_type t;
      logic [INDEX_W-1:0] corner [4];
      t = locate_taps(sx, sy);
      corner[0] = t.a00;
      corner[1] = t.a10;
      corner[2] = t.a01;
      corner[3] = t.a11;
      for (int i = 0; i < 4; i++) begin
         if (!pixel_known[corner[i]]) begin
            send_beat(OP_WRITE, corner[i], PIX_W'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), LEVEL_PREDICT, '0);
         end
      end
      send_beat(OP_SAMPLE, INDEX_W'($urandom), PIX_W'($urandom), sx, sy, typed, level);
   endtask

   // Drop start, wait for every pending level, then let a trailing write settle
   task automatic drain_results();
      start <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprogram the geometry with the pipeline empty
   task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      csr_index        <= CSR_IMAGE_HEIGHT;
      csr_write_data   <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_width  = w;
      cfg_height = h;
      geometries++;
   endtask

   // Mostly just around the image, some anywhere, a few at the coordinate extremes
   function automatic logic signed [COORD_BITS-1:0] pick_coord(input int extent);
      int r, v;
      r = $urandom_range(99);
      if (r < 65) begin
         v = int'($urandom_range((extent + 6) * FRAC_ONE - 1, 0)) - 3 * FRAC_ONE;
      end else if (r < 88) begin
         v = int'($urandom);
      end else begin
         case ($urandom_range(4))
            0:       v = -524288;
            1:       v = 524287;
            2:       v = -1;
            3:       v = 0;
            default: v = extent * FRAC_ONE - 1;
         endcase
      end
      return v[COORD_BITS-1:0];
   endfunction

   // Directed rows at the reset geometry of 256 by 256
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // corner block at the origin with one bright pixel, plus a bright far corner
      '{OP_WRITE,  16'd0,     8'd255, 20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'd1,     8'd0,   20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'd256,   8'd0,   20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'd257,   8'd0,   20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'd65535, 8'd255, 20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      // exact pixel hit gives full scale
      '{OP_SAMPLE, 16'd0,     8'd0,   20'sd0,      20'sd0,      LEVEL_TYPED,   16'd65280},
      // most negative coordinates clamp to the origin
      '{OP_SAMPLE, 16'd0,     8'd0,   20'h80000,   20'h80000,   LEVEL_TYPED,   16'd65280},
      // most positive coordinates clamp to the far corner
      '{OP_SAMPLE, 16'd0,     8'd0,   20'h7FFFF,   20'h7FFFF,   LEVEL_TYPED,   16'd65280},
      // half way across, then half way both ways
      '{OP_SAMPLE, 16'd0,     8'd0,   20'sd128,    20'sd0,      LEVEL_TYPED,   16'd32640},
      '{OP_SAMPLE, 16'd0,     8'd0,   20'sd128,    20'sd128,    LEVEL_TYPED,   16'd16320},
      // just below zero: both neighbours clamp onto the origin
      '{OP_SAMPLE, 16'd0,     8'd0,   -20'sd1,     -20'sd1,     LEVEL_TYPED,   16'd65280},
      // block at (4,4) set up so that the sum lands exactly on a half unit
      '{OP_WRITE,  16'd1028,  8'd1,   20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'd1029,  8'd0,   20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'd1284,  8'd0,   20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'd1285,  8'd0,   20'sd0,      20'sd0,      LEVEL_PREDICT, 16'd0},
      '{OP_SAMPLE, 16'd0,     8'd0,   20'sd1279,   20'sd1152,   LEVEL_TYPED,   16'd1},
      // overwrite the top address with zero and read it back through the clamp
      '{OP_WRITE,  16'd65535, 8'd0,   20'h7FFFF,   20'h7FFFF,   LEVEL_PREDICT, 16'd0},
      '{OP_SAMPLE, 16'hFFFF,  8'hFF,  20'h7FFFF,   20'h7FFFF,   LEVEL_TYPED,   16'd0},
      // alternating bit patterns, then predicted samples inside and across edges
      '{OP_WRITE,  16'hAAAA,  8'h55,  20'h55555,   20'hAAAAA,   LEVEL_PREDICT, 16'd0},
      '{OP_WRITE,  16'h5555,  8'hAA,  20'hAAAAA,   20'h55555,   LEVEL_PREDICT, 16'd0},
      '{OP_SAMPLE, 16'd0,     8'd0,   20'sd300,    20'sd700,    LEVEL_PREDICT, 16'd0},
      '{OP_SAMPLE, 16'd0,     8'd0,   -20'sd300,   20'sd65000,  LEVEL_PREDICT, 16'd0}
   };

   // Result side: every strobe is checked against the oldest pending level
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid === 1'b1) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid === 1'b1) begin
            results_seen++;
            if (expected_levels.size() == 0) begin
               report_mismatch("unexpected result, sample_value", int'(rsp_sample_value), -1);
            end else if (rsp_sample_value !== expected_levels[0]) begin
               report_mismatch("sample_value", int'(rsp_sample_value),
                               int'(expected_levels[0]));
               void'(expected_levels.pop_front());
            end else begin
               void'(expected_levels.pop_front());
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid unknown", 0, 0);
         end
      end
   end

   // Hang detector: nothing moving on either side for too long ends the run
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout after %0d quiet cycles, %0d levels pending",
               quiet_cycles, expected_levels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] w, h;
      int ext_w, ext_h;
      int phase_base;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, back to back
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].op == OP_SAMPLE) begin
            send_sample(directed_rows[i].x, directed_rows[i].y,
                        directed_rows[i].typed, directed_rows[i].level);
         end else begin
            send_beat(directed_rows[i].op, directed_rows[i].index, directed_rows[i].value,
                      directed_rows[i].x, directed_rows[i].y, LEVEL_PREDICT, '0);
         end
      end

      // random part: one geometry per phase, idling pattern rotates
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       begin w = 9'd256; h = 9'd256; end
            1:       begin w = 9'd0;   h = 9'd0;   end
            2:       begin w = 9'd1;   h = 9'd256; end
            3:       begin w = 9'd256; h = 9'd1;   end
            4:       begin w = 9'd511; h = 9'd511; end
            5:       begin w = 9'd300; h = 9'd7;   end
            6:       begin w = 9'd2;   h = 9'd2;   end
            default: begin
               w = CFG_W'($urandom_range(256, 1));
               h = CFG_W'($urandom_range(256, 1));
            end
         endcase
         set_geometry(w, h);
         case (phase % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 55;
            default: idle_pct = 21;
         endcase
         ext_w = effective_extent(cfg_width, MAX_WIDTH);
         ext_h = effective_extent(cfg_height, MAX_HEIGHT);
         // fill writes count towards the phase budget
         phase_base = writes_sent + samples_sent;
         while (writes_sent + samples_sent - phase_base < PHASE_BEATS) begin
            // now and then hold the sender off until every level is back
            if ($urandom_range(99) == 0) drain_results();
            if ($urandom_range(99) < 35) begin
               send_beat(OP_WRITE, INDEX_W'($urandom), PIX_W'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom), LEVEL_PREDICT, '0);
            end else begin
               send_sample(pick_coord(ext_w), pick_coord(ext_h), LEVEL_PREDICT, '0);
            end
         end
      end

      drain_results();
      $display("run covered %0d samples and %0d pixel writes over %0d geometries",
               samples_sent, writes_sent, geometries);
      $display("%0d results checked, %0d mismatches", results_seen, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bis_pkg.sv
design/bis_ram.sv
design/bis_coord.sv
design/bis_blend.sv
design/bilinear_image_sampler_unit.sv
verif/testbench.sv
